@@ rtl/core/reb_pkg.sv @@
`timescale 1ns / 1ps

package reb_pkg;

  localparam int unsigned TimeWidthDefault = 32;
  localparam int unsigned CfgDataWidth     = 16;
  localparam int unsigned CfgIdxWidth      = 2;

  localparam logic [4:0]  PpdReset       = 5'd4;
  localparam logic [15:0] DebounceReset  = 16'd20;
  localparam logic [15:0] LongPressReset = 16'd800;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgPulsesPerDetent = 2'd0,
    CfgDebounceMs      = 2'd1,
    CfgLongPressMs     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StepZero = 2'b00,
    StepUp   = 2'b01,
    StepDown = 2'b11
  } quad_step_e;

  typedef struct packed {
    logic        enc_a;
    logic        enc_b;
    logic        button_level;
    logic [31:0] now_ms;
    logic        take_rotation;
    logic        take_click;
    logic        take_long_press;
  } in_word_t;

  typedef struct packed {
    logic signed [7:0] rotation;
    logic              clicked;
    logic              long_pressed;
    logic              button_down;
  } out_word_t;

  typedef struct packed {
    logic clicked;
    logic long_pressed;
    logic button_down;
  } btn_status_t;

  // Rows are the previous AB code, columns the new one, A is the high bit.
  function automatic quad_step_e quad_step(input logic [1:0] prev, input logic [1:0] code);
    quad_step_e step;
    step = StepZero;
    unique case ({prev, code})
      4'b0001, 4'b0111, 4'b1000, 4'b1110: step = StepDown;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: step = StepUp;
      default:                            step = StepZero;
    endcase
    return step;
  endfunction

endpackage

@@ rtl/core/reb_quad.sv @@
`timescale 1ns / 1ps

module reb_quad (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [4:0]        ppd_i,
  input  logic              enc_a_i,
  input  logic              enc_b_i,
  input  logic              take_i,
  output logic signed [7:0] rotation_o
);

  logic [1:0]        prev_q, prev_d;
  logic signed [5:0] sum_q, sum_d;
  logic signed [7:0] det_q, det_d;

  logic [1:0]        code;
  logic [4:0]        ppd;
  logic signed [5:0] ppd_s;
  logic signed [5:0] sum_step;
  logic signed [7:0] det_new;
  reb_pkg::quad_step_e step;

  always_comb begin
    code = {enc_a_i, enc_b_i};
    if (ppd_i == 5'd0) begin
      ppd = 5'd1;
    end else if (ppd_i > 5'd16) begin
      ppd = 5'd16;
    end else begin
      ppd = ppd_i;
    end
    ppd_s = $signed({1'b0, ppd});
    step = reb_pkg::quad_step(prev_q, code);
    sum_step = sum_q + $signed({{4{step[1]}}, step});
    det_new = det_q;
    sum_d = sum_step;
    if (sum_step >= ppd_s) begin
      sum_d = sum_step - ppd_s;
      if (det_q != 8'sd127) begin
        det_new = det_q + 8'sd1;
      end
    end else if (sum_step <= -ppd_s) begin
      sum_d = sum_step + ppd_s;
      if (det_q != -8'sd128) begin
        det_new = det_q - 8'sd1;
      end
    end
    prev_d = code;
    det_d = take_i ? 8'sd0 : det_new;
    rotation_o = det_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 2'b11;
      sum_q  <= '0;
      det_q  <= '0;
    end else if (accept_i) begin
      prev_q <= prev_d;
      sum_q  <= sum_d;
      det_q  <= det_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_sum_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_q <= 6'sd16) && (sum_q >= -6'sd16))
    else $error("pulse sum left its range");
`endif

endmodule

@@ rtl/core/reb_button.sv @@
`timescale 1ns / 1ps

module reb_button #(
  parameter int unsigned TimeWidth = reb_pkg::TimeWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 button_level_i,
  input  logic [31:0]          now_ms_i,
  input  logic [15:0]          debounce_ms_i,
  input  logic [15:0]          long_press_ms_i,
  input  logic                 take_click_i,
  input  logic                 take_long_i,
  output reb_pkg::btn_status_t status_o
);

  logic                 raw_prev_q;
  logic [TimeWidth-1:0] last_change_q, last_change_d;
  logic                 stable_q, stable_d;
  logic [TimeWidth-1:0] press_start_q, press_start_d;
  logic                 fired_q, fired_d;
  logic                 click_q, click_d;
  logic                 long_q, long_d;

  logic [TimeWidth-1:0] now_t;
  logic                 raw;
  logic                 toggle;
  logic                 fired_mid;
  logic                 click_mid;
  logic                 long_fire;

  always_comb begin
    now_t = TimeWidth'(now_ms_i);
    raw = ~button_level_i;
    last_change_d = (raw != raw_prev_q) ? now_t : last_change_q;
    toggle = ((now_t - last_change_d) >= TimeWidth'(debounce_ms_i)) && (raw != stable_q);
    stable_d = toggle ? raw : stable_q;
    press_start_d = (toggle && raw) ? now_t : press_start_q;
    fired_mid = (toggle && raw) ? 1'b0 : fired_q;
    click_mid = click_q | (toggle && !raw && !fired_q);
    long_fire = stable_d && !fired_mid &&
                ((now_t - press_start_d) >= TimeWidth'(long_press_ms_i));
    fired_d = fired_mid | long_fire;
    click_d = click_mid & ~take_click_i;
    long_d = (long_q | long_fire) & ~take_long_i;
    status_o.clicked = click_mid;
    status_o.long_pressed = long_q | long_fire;
    status_o.button_down = stable_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_prev_q    <= 1'b0;
      last_change_q <= '0;
      stable_q      <= 1'b0;
      press_start_q <= '0;
      fired_q       <= 1'b0;
      click_q       <= 1'b0;
      long_q        <= 1'b0;
    end else if (accept_i) begin
      raw_prev_q    <= raw;
      last_change_q <= last_change_d;
      stable_q      <= stable_d;
      press_start_q <= press_start_d;
      fired_q       <= fired_d;
      click_q       <= click_d;
      long_q        <= long_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_long_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(long_q) |-> fired_q)
    else $error("long press flagged without the hold being marked");
  a_click_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(click_q) |-> !stable_q)
    else $error("click flagged while the button is still down");
`endif

endmodule

@@ rtl/core/rotary_encoder_with_button_unit.sv @@
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o  | in_data_i (reb_pkg::in_word_t)
// out     | output    | out_valid_o/out_ready_i | out_data_o (reb_pkg::out_word_t)
// cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// Each word is handled combinationally by the decode and debounce logic and its result is
// registered, so the result appears in the cycle after the word is accepted.
// A new word is accepted every cycle while the output register is empty or being taken.
// A stall on the output holds the result and blocks the input until it is taken.
// Reset restores the register defaults and the idle encoder and button state.

module rotary_encoder_with_button_unit #(
  parameter int unsigned TimeWidth = reb_pkg::TimeWidthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  reb_pkg::in_word_t                     in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output reb_pkg::out_word_t                    out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [reb_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  logic [reb_pkg::CfgDataWidth-1:0]      cfg_wdata_i
);

  logic [4:0]  ppd_q;
  logic [15:0] debounce_q;
  logic [15:0] long_press_q;

  logic                 out_valid_q;
  reb_pkg::out_word_t   out_data_q;
  logic                 accept;
  logic signed [7:0]    rotation;
  reb_pkg::btn_status_t status;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppd_q        <= reb_pkg::PpdReset;
      debounce_q   <= reb_pkg::DebounceReset;
      long_press_q <= reb_pkg::LongPressReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        reb_pkg::CfgPulsesPerDetent: ppd_q        <= cfg_wdata_i[4:0];
        reb_pkg::CfgDebounceMs:      debounce_q   <= cfg_wdata_i;
        reb_pkg::CfgLongPressMs:     long_press_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  reb_quad u_quad (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .ppd_i      (ppd_q),
    .enc_a_i    (in_data_i.enc_a),
    .enc_b_i    (in_data_i.enc_b),
    .take_i     (in_data_i.take_rotation),
    .rotation_o (rotation)
  );

  reb_button #(
    .TimeWidth (TimeWidth)
  ) u_button (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .button_level_i  (in_data_i.button_level),
    .now_ms_i        (in_data_i.now_ms),
    .debounce_ms_i   (debounce_q),
    .long_press_ms_i (long_press_q),
    .take_click_i    (in_data_i.take_click),
    .take_long_i     (in_data_i.take_long_press),
    .status_o        (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q.rotation     <= rotation;
      out_data_q.clicked      <= status.clicked;
      out_data_q.long_pressed <= status.long_pressed;
      out_data_q.button_down  <= status.button_down;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted word produced no result");
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while a result is held");
`endif

endmodule
